// File: rtl/u8san_pkg.sv
// Shared types and defaults for the UTF-8 sanitizer with hex escapes.
// Holds the command format passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package u8san_pkg;

  // Longest sequence a lead byte may announce.
  localparam int MAX_SEQUENCE_BYTES = 6;

  // Entries in the command queue between the front end and the back end.
  localparam int CMD_QUEUE_DEPTH = 4;

  // What the back end does with one queued byte.
  typedef enum logic [1:0] {
    CMD_EMIT,    // pass the byte through as it is
    CMD_ESCAPE,  // write the byte as [XY]
    CMD_TERM     // close the string: terminator result with changed flag
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

endpackage

// File: rtl/u8san_front.sv
// Front end: accepts text bytes, tracks the pending UTF-8 sequence and
// queues emit / escape / terminator commands. Uses u8san_pkg.
`timescale 1ns / 1ps

module u8san_front #(
  parameter int MAX_SEQUENCE_BYTES = u8san_pkg::MAX_SEQUENCE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       control_mask,
  input  logic              text_valid,
  output logic              text_ready,
  input  logic [7:0]        text_byte,
  input  logic              string_end,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output u8san_pkg::cmd_t   cmd
);

  localparam int SEQ_W = $clog2(MAX_SEQUENCE_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_SEQUENCE_BYTES);
  // lead bits kept plus six bits for each continuation byte
  localparam int ACC_W = (8 - MAX_SEQUENCE_BYTES) + 6 * (MAX_SEQUENCE_BYTES - 1);

  typedef enum logic [1:0] {S_IDLE, S_FLUSH, S_PEND} state_t;

  state_t           state, state_next;
  logic [SEQ_W-1:0] count, count_next;
  logic [SEQ_W-1:0] seq_len, seq_len_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [IDX_W-1:0] flush_idx, flush_idx_next;
  logic             flush_esc, flush_esc_next;
  logic             pend_valid, pend_valid_next;
  logic             pend_end, pend_end_next;
  logic [7:0]       pend_byte, pend_byte_next;

  logic [7:0]       held [MAX_SEQUENCE_BYTES];
  logic             held_we;
  logic [IDX_W-1:0] held_widx;
  logic [7:0]       held_wdata;

  logic [7:0]           fresh_byte;
  logic                 fresh_is_lead;
  logic                 fresh_esc;
  u8san_pkg::cmd_kind_t fresh_kind;
  logic [SEQ_W-1:0]     lead_n;
  logic                 lead_run;
  logic [7:0]           lead_bits;
  logic [ACC_W-1:0]     acc_lead;
  logic [ACC_W-1:0]     acc_upd;
  logic [SEQ_W-1:0]     cnt_upd;
  logic                 flush_last;

  // Classification of a byte seen with nothing held.
  assign fresh_byte    = (state == S_PEND) ? pend_byte : text_byte;
  assign fresh_is_lead = (fresh_byte[7:6] == 2'b11);
  assign fresh_esc     = (fresh_byte[7:6] == 2'b10) ||
                         ((fresh_byte[7:5] == 3'b000) && control_mask[fresh_byte[4:0]]);
  assign fresh_kind    = fresh_esc ? u8san_pkg::CMD_ESCAPE : u8san_pkg::CMD_EMIT;

  // Leading ones of the lead byte, capped at the longest sequence.
  always_comb begin
    lead_n   = '0;
    lead_run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (lead_run && fresh_byte[7-i] && (lead_n < SEQ_W'(MAX_SEQUENCE_BYTES))) begin
        lead_n = lead_n + SEQ_W'(1);
      end else begin
        lead_run = 1'b0;
      end
    end
  end

  assign lead_bits  = 8'hFF >> lead_n;
  assign acc_lead   = ACC_W'(fresh_byte & lead_bits);
  assign acc_upd    = {acc[ACC_W-7:0], text_byte[5:0]};
  assign cnt_upd    = count + SEQ_W'(1);
  assign flush_last = ((SEQ_W'(flush_idx) + SEQ_W'(1)) == count);
  assign text_ready = (state == S_IDLE) && cmd_ready;

  always_comb begin
    state_next      = state;
    count_next      = count;
    seq_len_next    = seq_len;
    acc_next        = acc;
    flush_idx_next  = flush_idx;
    flush_esc_next  = flush_esc;
    pend_valid_next = pend_valid;
    pend_end_next   = pend_end;
    pend_byte_next  = pend_byte;
    held_we         = 1'b0;
    held_widx       = '0;
    held_wdata      = fresh_byte;
    cmd_valid       = 1'b0;
    cmd.kind        = fresh_kind;
    cmd.data        = fresh_byte;

    unique case (state)
      S_IDLE: begin
        if (text_valid && cmd_ready) begin
          if (string_end) begin
            if (count == '0) begin
              cmd_valid = 1'b1;
              cmd.kind  = u8san_pkg::CMD_TERM;
              cmd.data  = 8'h00;
            end else begin
              // unfinished sequence at the end: escape all of it
              state_next      = S_FLUSH;
              flush_idx_next  = '0;
              flush_esc_next  = 1'b1;
              pend_valid_next = 1'b1;
              pend_end_next   = 1'b1;
            end
          end else if (count == '0) begin
            if (fresh_is_lead) begin
              count_next   = SEQ_W'(1);
              seq_len_next = lead_n;
              acc_next     = acc_lead;
              held_we      = 1'b1;
            end else begin
              cmd_valid = 1'b1;
            end
          end else if (text_byte[7:6] == 2'b10) begin
            held_we    = 1'b1;
            held_widx  = count[IDX_W-1:0];
            held_wdata = text_byte;
            acc_next   = acc_upd;
            count_next = cnt_upd;
            if (cnt_upd == seq_len) begin
              // sequence complete: pass it, or escape it all if it decodes
              // into the ASCII range
              state_next      = S_FLUSH;
              flush_idx_next  = '0;
              flush_esc_next  = (acc_upd[ACC_W-1:7] == '0);
              pend_valid_next = 1'b0;
            end
          end else begin
            // broken sequence: escape what is held, then take this byte fresh
            state_next      = S_FLUSH;
            flush_idx_next  = '0;
            flush_esc_next  = 1'b1;
            pend_valid_next = 1'b1;
            pend_end_next   = 1'b0;
            pend_byte_next  = text_byte;
          end
        end
      end

      S_FLUSH: begin
        cmd_valid = 1'b1;
        cmd.kind  = flush_esc ? u8san_pkg::CMD_ESCAPE : u8san_pkg::CMD_EMIT;
        cmd.data  = held[flush_idx];
        if (cmd_ready) begin
          if (flush_last) begin
            count_next   = '0;
            seq_len_next = '0;
            acc_next     = '0;
            state_next   = pend_valid ? S_PEND : S_IDLE;
          end else begin
            flush_idx_next = flush_idx + IDX_W'(1);
          end
        end
      end

      S_PEND: begin
        if (pend_end) begin
          cmd_valid = 1'b1;
          cmd.kind  = u8san_pkg::CMD_TERM;
          cmd.data  = 8'h00;
          if (cmd_ready) begin
            state_next      = S_IDLE;
            pend_valid_next = 1'b0;
          end
        end else if (fresh_is_lead) begin
          count_next      = SEQ_W'(1);
          seq_len_next    = lead_n;
          acc_next        = acc_lead;
          held_we         = 1'b1;
          state_next      = S_IDLE;
          pend_valid_next = 1'b0;
        end else begin
          cmd_valid = 1'b1;
          if (cmd_ready) begin
            state_next      = S_IDLE;
            pend_valid_next = 1'b0;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      seq_len    <= '0;
      acc        <= '0;
      flush_idx  <= '0;
      flush_esc  <= 1'b0;
      pend_valid <= 1'b0;
      pend_end   <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      seq_len    <= seq_len_next;
      acc        <= acc_next;
      flush_idx  <= flush_idx_next;
      flush_esc  <= flush_esc_next;
      pend_valid <= pend_valid_next;
      pend_end   <= pend_end_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte <= pend_byte_next;
    if (held_we) begin
      held[held_widx] <= held_wdata;
    end
  end

  a_hold_shape: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && (count != '0) |-> (count < seq_len) && (seq_len >= SEQ_W'(2)))
    else $error("held count out of range for announced sequence");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (count != '0) && (SEQ_W'(flush_idx) < count))
    else $error("flush index beyond held bytes");

  a_lead_held: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && !string_end && (count == '0) && (text_byte[7:6] == 2'b11)
    |=> (count == SEQ_W'(1)) && (state == S_IDLE))
    else $error("lead byte not held");

endmodule

// File: rtl/u8san_cmd_fifo.sv
// Short command queue between the sanitizer front end and back end.
// Uses u8san_pkg for the command format.
`timescale 1ns / 1ps

module u8san_cmd_fifo #(
  parameter int DEPTH = u8san_pkg::CMD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  u8san_pkg::cmd_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output u8san_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8san_pkg::cmd_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/u8san_back.sv
// Back end: expands queued commands into output bytes, writes [XY] escapes
// and keeps the per-string changed flag. Uses u8san_pkg.
`timescale 1ns / 1ps

module u8san_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  u8san_pkg::cmd_t cmd,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [7:0]      out_byte,
  output logic            end_of_output,
  output logic            string_changed
);

  localparam logic [7:0] CH_OPEN    = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE   = 8'h5D;  // ']'
  localparam logic [1:0] PHASE_LAST = 2'd3;
  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  logic [1:0] phase;
  logic       changed;
  logic       load;
  logic       last;
  logic [7:0] byte_next;
  logic       eo_next;
  logic       ch_next;

  assign load      = cmd_valid && (!result_valid || result_ready);
  assign last      = (cmd.kind != u8san_pkg::CMD_ESCAPE) || (phase == PHASE_LAST);
  assign cmd_ready = load && last;

  always_comb begin
    byte_next = cmd.data;
    eo_next   = 1'b0;
    ch_next   = 1'b0;
    unique case (cmd.kind)
      u8san_pkg::CMD_EMIT: begin
        byte_next = cmd.data;
      end
      u8san_pkg::CMD_ESCAPE: begin
        case (phase)
          2'd0:    byte_next = CH_OPEN;
          2'd1:    byte_next = HEX_DIGITS[cmd.data[7:4]];
          2'd2:    byte_next = HEX_DIGITS[cmd.data[3:0]];
          default: byte_next = CH_CLOSE;
        endcase
      end
      u8san_pkg::CMD_TERM: begin
        byte_next = 8'h00;
        eo_next   = 1'b1;
        ch_next   = changed;
      end
      default: begin
        byte_next = cmd.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= '0;
      changed      <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        phase        <= last ? 2'd0 : phase + 2'd1;
        if (cmd.kind == u8san_pkg::CMD_ESCAPE) begin
          changed <= 1'b1;
        end else if (cmd.kind == u8san_pkg::CMD_TERM) begin
          changed <= 1'b0;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= byte_next;
      end_of_output  <= eo_next;
      string_changed <= ch_next;
    end
  end

  a_escape_holds_head: assert property (@(posedge clk) disable iff (rst)
    (phase != 2'd0) |-> cmd_valid && (cmd.kind == u8san_pkg::CMD_ESCAPE))
    else $error("escape in progress without its command at the queue head");

  a_changed_on_term: assert property (@(posedge clk) disable iff (rst)
    result_valid && string_changed |-> end_of_output)
    else $error("changed flag shown on a data byte");

  a_term_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && end_of_output |-> (out_byte == 8'h00))
    else $error("terminator carries a nonzero byte");

endmodule

// File: rtl/utf8_sanitizer_hex_escape_top.sv
// UTF-8 sanitizer with [XY] hex escapes.
// Plain bytes go at 1 per cycle while the command queue has room and the output is
// taken; each escape is written as four output bytes in the back end.
// A byte that completes a held sequence holds the input off while the front end walks it
// out; so does a byte or end marker that breaks one.
// Synchronous active-high reset clears all control state and control_mask.
`timescale 1ns / 1ps

module utf8_sanitizer_hex_escape_top #(
  parameter int MAX_SEQUENCE_BYTES = u8san_pkg::MAX_SEQUENCE_BYTES,
  parameter int CMD_QUEUE_DEPTH    = u8san_pkg::CMD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // text byte requests
  input  logic        text_valid,
  output logic        text_ready,
  input  logic [7:0]  text_byte,
  input  logic        string_end,
  // result requests
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  out_byte,
  output logic        end_of_output,
  output logic        string_changed
);

  // Register index 0 is control_mask, at byte address 0; bit 2 of paddr
  // picks the word.
  localparam logic REG_CONTROL_MASK = 1'b0;

  logic [31:0]     control_mask;
  logic            reg_index;
  logic            cfg_write;

  logic            fe_cmd_valid;
  logic            fe_cmd_ready;
  u8san_pkg::cmd_t fe_cmd;
  logic            be_cmd_valid;
  logic            be_cmd_ready;
  u8san_pkg::cmd_t be_cmd;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_CONTROL_MASK) ? control_mask : 32'h0;

  // Writes to any other index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_mask <= '0;
    end else if (cfg_write && (reg_index == REG_CONTROL_MASK)) begin
      control_mask <= pwdata;
    end
  end

  // Front end: sequence tracking and classification. It holds the bytes of
  // the sequence in progress and, when the sequence completes or breaks,
  // walks them one per cycle, while the queue has room, into the command queue.
  u8san_front #(
    .MAX_SEQUENCE_BYTES (MAX_SEQUENCE_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .control_mask (control_mask),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .string_end   (string_end),
    .cmd_valid    (fe_cmd_valid),
    .cmd_ready    (fe_cmd_ready),
    .cmd          (fe_cmd)
  );

  // Decouples the front end from the back end while the back end writes out escapes.
  u8san_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fe_cmd_valid),
    .push_ready (fe_cmd_ready),
    .push_data  (fe_cmd),
    .pop_valid  (be_cmd_valid),
    .pop_ready  (be_cmd_ready),
    .pop_data   (be_cmd)
  );

  // Back end: byte expansion into the registered output stage, plus the
  // per-string changed flag reported on the terminator.
  u8san_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (be_cmd_valid),
    .cmd_ready      (be_cmd_ready),
    .cmd            (be_cmd),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .out_byte       (out_byte),
    .end_of_output  (end_of_output),
    .string_changed (string_changed)
  );

endmodule
